// ===== rtl/uob_pkg.sv =====
// Shared types, codes and constants for the obstacle bypass controller.
`timescale 1ns / 1ps

package uob_pkg;

   // Fixed-point layout of ranges and the scaled threshold
   localparam int RANGE_FRAC_BITS = 4;
   localparam int RANGE_W         = 16;
   localparam int THR_CM_W        = 12;
   localparam int THR_W           = THR_CM_W + RANGE_FRAC_BITS;
   localparam int CMP_W           = (THR_W > RANGE_W) ? THR_W : RANGE_W;
   localparam int COUNT_W         = 16;
   localparam int MAG_W           = COUNT_W + 1;
   localparam int TARGET_W        = 15;
   localparam int PHASE_W         = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_TGT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_TGT    = 2'd2;

   // Navigation modes
   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_GOING     = 2'd1;
   localparam logic [1:0] MODE_RETURNING = 2'd2;
   localparam logic [1:0] MODE_OTHER     = 2'd3;

   // Bypass phases
   localparam logic [PHASE_W-1:0] PH_NORMAL      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_CHECK_FRONT = 4'd1;
   localparam logic [PHASE_W-1:0] PH_CHECK_LEFT  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_CHECK_RIGHT = 4'd3;
   localparam logic [PHASE_W-1:0] PH_DECIDE      = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SHIFT_OUT   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_FORWARD     = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SHIFT_BACK  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_ABORT       = 4'd8;

   // Command values
   localparam logic [5:0]        FWD_SPEED   = 6'd50;
   localparam logic signed [6:0] LAT_LEFT    = 7'sd60;
   localparam logic signed [6:0] LAT_RIGHT   = -7'sd60;
   localparam logic [7:0]        ANGLE_RIGHT = 8'd0;
   localparam logic [7:0]        ANGLE_FRONT = 8'd90;
   localparam logic [7:0]        ANGLE_LEFT  = 8'd180;

   typedef struct packed {
      logic [RANGE_W-1:0]        distance_sixteenths;
      logic [1:0]                nav_mode;
      logic signed [COUNT_W-1:0] wheel_count_a;
      logic signed [COUNT_W-1:0] wheel_count_b;
      logic signed [COUNT_W-1:0] wheel_count_c;
      logic signed [COUNT_W-1:0] wheel_count_d;
   } req_item_type;

   typedef struct packed {
      logic              drive_valid;
      logic [5:0]        forward_speed;
      logic signed [6:0] lateral_speed;
      logic              servo_valid;
      logic [7:0]        servo_angle;
      logic              clear_encoders;
      logic              line_follow_hold;
      logic              fully_blocked;
      logic [PHASE_W-1:0] bypass_phase;
   } rsp_item_type;

   typedef struct packed {
      logic [THR_CM_W-1:0] obstacle_threshold_cm;
      logic [TARGET_W-1:0] shift_count_target;
      logic [TARGET_W-1:0] forward_count_target;
   } cfg_type;

endpackage

// ===== rtl/uob_csr.sv =====
// Configuration registers of the obstacle bypass controller.
`timescale 1ns / 1ps

module uob_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [uob_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uob_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output uob_pkg::cfg_type               cfg
);
   import uob_pkg::*;

   cfg_type cfg_ff;

   // Write the addressed register; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_threshold_cm <= THR_CM_W'(40);
         cfg_ff.shift_count_target    <= TARGET_W'(1000);
         cfg_ff.forward_count_target  <= TARGET_W'(4000);
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.obstacle_threshold_cm <= csr_wdata[THR_CM_W-1:0];
            CSR_SHIFT_TGT: cfg_ff.shift_count_target    <= csr_wdata[TARGET_W-1:0];
            CSR_FWD_TGT:   cfg_ff.forward_count_target  <= csr_wdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/uob_mean.sv =====
// Mean absolute wheel encoder count over the four wheels.
`timescale 1ns / 1ps

module uob_mean (
   input  uob_pkg::req_item_type      item,
   output logic [uob_pkg::MAG_W-1:0]  mean
);
   import uob_pkg::*;

   logic [MAG_W+1:0] sum;

   // Two's complement magnitude, one bit wider so the most negative count fits
   function automatic logic [MAG_W-1:0] magnitude(input logic signed [COUNT_W-1:0] w);
      logic [MAG_W-1:0] ext;
      ext = {w[COUNT_W-1], w};
      magnitude = w[COUNT_W-1] ? (~ext + MAG_W'(1)) : ext;
   endfunction

   // Add the four magnitudes, then divide by four with a shift
   always_comb begin
      sum = (MAG_W+2)'(magnitude(item.wheel_count_a)) +
            (MAG_W+2)'(magnitude(item.wheel_count_b)) +
            (MAG_W+2)'(magnitude(item.wheel_count_c)) +
            (MAG_W+2)'(magnitude(item.wheel_count_d));
      mean = sum[MAG_W+1:2];
   end

endmodule

// ===== rtl/uob_ctrl.sv =====
// Bypass state machine: scan ranges, side choice and per-item commands.
`timescale 1ns / 1ps

module uob_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  uob_pkg::req_item_type      item,
   input  logic [uob_pkg::MAG_W-1:0]  mean,
   input  uob_pkg::cfg_type           cfg,
   output uob_pkg::rsp_item_type      result
);
   import uob_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_eff;
   logic [RANGE_W-1:0] front_ff, front_in;
   logic [RANGE_W-1:0] left_ff, left_in;
   logic [RANGE_W-1:0] right_ff, right_in;
   logic               shift_left_ff, shift_left_in;
   logic               hold_ff, hold_in;

   logic [CMP_W-1:0]   thr;
   logic [CMP_W-1:0]   range_now;
   logic [CMP_W-1:0]   front_x, left_x, right_x;
   logic               shift_done, forward_done;

   // Scale threshold to 1/16 cm and line everything up at one width
   always_comb begin
      thr       = CMP_W'({cfg.obstacle_threshold_cm, {RANGE_FRAC_BITS{1'b0}}});
      range_now = CMP_W'(item.distance_sixteenths);
      front_x   = CMP_W'(front_ff);
      left_x    = CMP_W'(left_ff);
      right_x   = CMP_W'(right_ff);
      shift_done   = mean >= MAG_W'(cfg.shift_count_target);
      forward_done = mean >= MAG_W'(cfg.forward_count_target);
   end

   // Next state and result for the item in the input register
   always_comb begin
      result        = '0;
      front_in      = front_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      shift_left_in = shift_left_ff;
      hold_in       = hold_ff;

      // Idle navigation during a bypass forces abort
      phase_eff = (item.nav_mode == MODE_IDLE && phase_ff != PH_NORMAL) ? PH_ABORT : phase_ff;
      phase_in  = phase_eff;

      if (item.nav_mode inside {MODE_GOING, MODE_RETURNING}) begin
         case (phase_eff)
            PH_NORMAL: begin
               if (range_now != '0 && range_now < thr) begin
                  hold_in            = 1'b1;
                  result.drive_valid = 1'b1;
                  result.servo_valid = 1'b1;
                  result.servo_angle = ANGLE_FRONT;
                  phase_in           = PH_CHECK_FRONT;
               end
            end
            PH_CHECK_FRONT: begin
               front_in           = item.distance_sixteenths;
               result.servo_valid = 1'b1;
               result.servo_angle = ANGLE_RIGHT;
               phase_in           = PH_CHECK_LEFT;
            end
            PH_CHECK_LEFT: begin
               left_in            = item.distance_sixteenths;
               result.servo_valid = 1'b1;
               result.servo_angle = ANGLE_LEFT;
               phase_in           = PH_CHECK_RIGHT;
            end
            PH_CHECK_RIGHT: begin
               right_in           = item.distance_sixteenths;
               result.servo_valid = 1'b1;
               result.servo_angle = ANGLE_FRONT;
               phase_in           = PH_DECIDE;
            end
            PH_DECIDE: begin
               result.drive_valid = 1'b1;
               if (front_x < thr && left_x < thr && right_x < thr) begin
                  result.fully_blocked = 1'b1;
                  hold_in              = 1'b0;
                  phase_in             = PH_NORMAL;
               end else begin
                  result.clear_encoders = 1'b1;
                  if (left_x > right_x && left_x > thr) begin
                     shift_left_in        = 1'b1;
                     result.lateral_speed = LAT_LEFT;
                  end else begin
                     shift_left_in        = 1'b0;
                     result.lateral_speed = LAT_RIGHT;
                  end
                  phase_in = PH_SHIFT_OUT;
               end
            end
            PH_SHIFT_OUT: begin
               if (shift_done) begin
                  result.drive_valid    = 1'b1;
                  result.clear_encoders = 1'b1;
                  result.forward_speed  = FWD_SPEED;
                  phase_in              = PH_FORWARD;
               end
            end
            PH_FORWARD: begin
               if (forward_done) begin
                  result.drive_valid    = 1'b1;
                  result.clear_encoders = 1'b1;
                  result.lateral_speed  = shift_left_ff ? LAT_RIGHT : LAT_LEFT;
                  phase_in              = PH_SHIFT_BACK;
               end
            end
            PH_SHIFT_BACK: begin
               if (shift_done) begin
                  result.drive_valid = 1'b1;
                  front_in           = '0;
                  left_in            = '0;
                  right_in           = '0;
                  hold_in            = 1'b0;
                  phase_in           = PH_NORMAL;
               end
            end
            default: begin
               // Abort and unused codes: stop, recenter servo, release drive
               result.drive_valid = 1'b1;
               result.servo_valid = 1'b1;
               result.servo_angle = ANGLE_FRONT;
               front_in           = '0;
               left_in            = '0;
               right_in           = '0;
               hold_in            = 1'b0;
               phase_in           = PH_NORMAL;
            end
         endcase
      end

      result.line_follow_hold = hold_in;
      result.bypass_phase     = phase_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         shift_left_ff <= 1'b0;
         hold_ff       <= 1'b0;
         front_ff      <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         shift_left_ff <= shift_left_in;
         hold_ff       <= hold_in;
         front_ff      <= front_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
      end
   end

endmodule

// ===== rtl/ultrasonic_obstacle_bypass_fsm_core.sv =====
// Top level of the ultrasonic obstacle bypass controller.
`timescale 1ns / 1ps

// Obstacle bypass controller: one request item (range, navigation mode, four
// wheel counts) in, exactly one response item out. An accepted item sits in
// the input register, where the state machine and the encoder mean evaluate
// it, and its response is captured in the output register when the item
// advances; a new item is taken every cycle as long as the output side keeps
// draining; a stalled response holds the input register, which then holds the
// request side. Configuration writes apply at once and are meant to be issued
// only while no item is in flight.
module ultrasonic_obstacle_bypass_fsm_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  uob_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output uob_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_we,
   input  logic [uob_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uob_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uob_pkg::*;

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   logic          advance;
   cfg_type       cfg;
   logic [MAG_W-1:0] mean;
   rsp_item_type  step_result;

   uob_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uob_mean u_mean (
      .item (in_item_ff),
      .mean (mean)
   );

   uob_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .mean    (mean),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Move the item forward when the output register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// ===== tb/tb_ultrasonic_obstacle_bypass_fsm_core.sv =====
// Self-checking testbench for the ultrasonic obstacle bypass controller.
`timescale 1ns / 1ps

module tb_ultrasonic_obstacle_bypass_fsm_core;
   import uob_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int ITEMS_PER_SET    = 270;
   localparam int NUM_SETTINGS     = 7;
   localparam int LONG_HOLD_AT     = 700;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int MAX_GAP          = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ultrasonic_obstacle_bypass_fsm_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Controller register copies, tracked alongside every write
   logic [THR_CM_W-1:0] thr_cm    = 12'd40;
   logic [TARGET_W-1:0] shift_tgt = 15'd1000;
   logic [TARGET_W-1:0] fwd_tgt   = 15'd4000;

   // Bypass state as the controller should hold it
   logic [PHASE_W-1:0] nav_phase  = PH_NORMAL;
   logic [RANGE_W-1:0] front_seen = '0;
   logic [RANGE_W-1:0] left_seen  = '0;
   logic [RANGE_W-1:0] right_seen = '0;
   logic               go_left    = 1'b0;
   logic               hold_line  = 1'b0;

   req_item_type pending_req_q[$];
   rsp_item_type expected_rsp_q[$];

   int  items_queued    = 0;
   int  items_accepted  = 0;
   int  results_checked = 0;
   int  error_count     = 0;
   int  cycle_count     = 0;
   int  blocked_stops   = 0;
   int  bypasses_done   = 0;
   int  aborts_seen     = 0;
   int  req_gap         = 0;
   int  rsp_stall       = 0;
   bit  req_took        = 1'b0;
   bit  rsp_took        = 1'b0;
   bit  burst_mode      = 1'b0;

   function automatic logic [MAG_W-1:0] wheel_mag(logic signed [COUNT_W-1:0] c);
      return c[COUNT_W-1] ? MAG_W'(17'h10000 - {1'b0, c}) : {1'b0, c};
   endfunction

   // Advance the bypass state by one item and form its command
   function automatic rsp_item_type bypass_step(req_item_type it);
      rsp_item_type       r;
      logic [RANGE_W-1:0] thr;
      logic [MAG_W+1:0]   mag_sum;
      logic [MAG_W-1:0]   mean;
      logic [RANGE_W-1:0] range_now;
      r         = '0;
      range_now = it.distance_sixteenths;
      thr       = RANGE_W'(thr_cm) << RANGE_FRAC_BITS;
      mag_sum   = (MAG_W+2)'(wheel_mag(it.wheel_count_a)) +
                  (MAG_W+2)'(wheel_mag(it.wheel_count_b)) +
                  (MAG_W+2)'(wheel_mag(it.wheel_count_c)) +
                  (MAG_W+2)'(wheel_mag(it.wheel_count_d));
      mean      = MAG_W'(mag_sum >> 2);

      // Idle navigation in mid-bypass drops to abort
      if (it.nav_mode == MODE_IDLE && nav_phase != PH_NORMAL) begin
         if (nav_phase != PH_ABORT) aborts_seen++;
         nav_phase = PH_ABORT;
      end

      if (it.nav_mode == MODE_GOING || it.nav_mode == MODE_RETURNING) begin
         case (nav_phase)
            PH_NORMAL: begin
               if (range_now != 0 && range_now < thr) begin
                  hold_line     = 1'b1;
                  r.drive_valid = 1'b1;
                  r.servo_valid = 1'b1;
                  r.servo_angle = ANGLE_FRONT;
                  nav_phase     = PH_CHECK_FRONT;
               end
            end
            PH_CHECK_FRONT: begin
               front_seen    = range_now;
               r.servo_valid = 1'b1;
               r.servo_angle = ANGLE_RIGHT;
               nav_phase     = PH_CHECK_LEFT;
            end
            PH_CHECK_LEFT: begin
               left_seen     = range_now;
               r.servo_valid = 1'b1;
               r.servo_angle = ANGLE_LEFT;
               nav_phase     = PH_CHECK_RIGHT;
            end
            PH_CHECK_RIGHT: begin
               right_seen    = range_now;
               r.servo_valid = 1'b1;
               r.servo_angle = ANGLE_FRONT;
               nav_phase     = PH_DECIDE;
            end
            PH_DECIDE: begin
               r.drive_valid = 1'b1;
               if (front_seen < thr && left_seen < thr && right_seen < thr) begin
                  r.fully_blocked = 1'b1;
                  hold_line       = 1'b0;
                  nav_phase       = PH_NORMAL;
                  blocked_stops++;
               end else begin
                  r.clear_encoders = 1'b1;
                  go_left = (left_seen > right_seen && left_seen > thr);
                  r.lateral_speed = go_left ? LAT_LEFT : LAT_RIGHT;
                  nav_phase = PH_SHIFT_OUT;
               end
            end
            PH_SHIFT_OUT: begin
               if (mean >= shift_tgt) begin
                  r.drive_valid    = 1'b1;
                  r.clear_encoders = 1'b1;
                  r.forward_speed  = FWD_SPEED;
                  nav_phase        = PH_FORWARD;
               end
            end
            PH_FORWARD: begin
               if (mean >= fwd_tgt) begin
                  r.drive_valid    = 1'b1;
                  r.clear_encoders = 1'b1;
                  r.lateral_speed  = go_left ? LAT_RIGHT : LAT_LEFT;
                  nav_phase        = PH_SHIFT_BACK;
               end
            end
            PH_SHIFT_BACK: begin
               if (mean >= shift_tgt) begin
                  r.drive_valid = 1'b1;
                  front_seen    = '0;
                  left_seen     = '0;
                  right_seen    = '0;
                  hold_line     = 1'b0;
                  nav_phase     = PH_NORMAL;
                  bypasses_done++;
               end
            end
            default: begin
               // Recover from abort: recenter the servo and release the drive
               r.drive_valid = 1'b1;
               r.servo_valid = 1'b1;
               r.servo_angle = ANGLE_FRONT;
               front_seen    = '0;
               left_seen     = '0;
               right_seen    = '0;
               hold_line     = 1'b0;
               nav_phase     = PH_NORMAL;
            end
         endcase
      end

      r.line_follow_hold = hold_line;
      r.bypass_phase     = nav_phase;
      return r;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic int draw_gap();
      if (burst_mode || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Predict on every accepted item, check every accepted result
   always @(posedge clock) begin
      rsp_item_type want;
      req_took = 1'b0;
      rsp_took = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(bypass_step(req_data));
            items_accepted++;
            req_took = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_took = 1'b1;
            results_checked++;
            if (expected_rsp_q.size() == 0) begin
               $error("result item with no expectation pending");
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("drive_valid", int'(want.drive_valid),
                             int'(rsp_data.drive_valid));
               compare_field("forward_speed", int'(want.forward_speed),
                             int'(rsp_data.forward_speed));
               compare_field("lateral_speed", int'(want.lateral_speed),
                             int'(rsp_data.lateral_speed));
               compare_field("servo_valid", int'(want.servo_valid),
                             int'(rsp_data.servo_valid));
               compare_field("servo_angle", int'(want.servo_angle),
                             int'(rsp_data.servo_angle));
               compare_field("clear_encoders", int'(want.clear_encoders),
                             int'(rsp_data.clear_encoders));
               compare_field("line_follow_hold", int'(want.line_follow_hold),
                             int'(rsp_data.line_follow_hold));
               compare_field("fully_blocked", int'(want.fully_blocked),
                             int'(rsp_data.fully_blocked));
               compare_field("bypass_phase", int'(want.bypass_phase),
                             int'(rsp_data.bypass_phase));
            end
         end
      end
   end

   // Request driver: hold valid until taken, then idle a drawn number of cycles
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (req_valid) req_gap = draw_gap();
         if (req_gap == 0 && pending_req_q.size() > 0) begin
            req_data  <= pending_req_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // Response side: stall a drawn number of cycles after each item, once for long
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            rsp_stall = draw_gap();
            if (results_checked == LONG_HOLD_AT) rsp_stall = LONG_HOLD_CYCLES;
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, expected_rsp_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_cm    = val[THR_CM_W-1:0];
         CSR_SHIFT_TGT: shift_tgt = val[TARGET_W-1:0];
         CSR_FWD_TGT:   fwd_tgt   = val[TARGET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(int thr, int shift_val, int fwd_val);
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_SHIFT_TGT, CSR_DATA_W'(shift_val));
      write_csr(CSR_FWD_TGT, CSR_DATA_W'(fwd_val));
   endtask

   task automatic wait_drained();
      while (items_accepted < items_queued || expected_rsp_q.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [1:0] active_mode();
      return $urandom_range(0, 1) ? MODE_GOING : MODE_RETURNING;
   endfunction

   function automatic logic signed [COUNT_W-1:0] signed_count(int unsigned mag);
      if (mag >= 32768) return 16'sh8000;
      return $urandom_range(0, 1) ? -COUNT_W'(mag) : COUNT_W'(mag);
   endfunction

   // Wheel magnitudes all at or above the target, or all below it
   function automatic int unsigned pick_mag(int unsigned target, bit reach);
      if (reach) return $urandom_range(target, 32768);
      if (target == 0) return 0;
      return $urandom_range(0, target - 1);
   endfunction

   function automatic req_item_type wheel_item(logic [RANGE_W-1:0] range_val,
                                               int unsigned target, bit reach);
      req_item_type it;
      it.distance_sixteenths = range_val;
      it.nav_mode            = active_mode();
      it.wheel_count_a       = signed_count(pick_mag(target, reach));
      it.wheel_count_b       = signed_count(pick_mag(target, reach));
      it.wheel_count_c       = signed_count(pick_mag(target, reach));
      it.wheel_count_d       = signed_count(pick_mag(target, reach));
      return it;
   endfunction

   function automatic req_item_type fixed_item(int range_val, logic [1:0] mode,
                                               int a, int b, int c, int d);
      req_item_type it;
      it.distance_sixteenths = RANGE_W'(range_val);
      it.nav_mode            = mode;
      it.wheel_count_a       = COUNT_W'(a);
      it.wheel_count_b       = COUNT_W'(b);
      it.wheel_count_c       = COUNT_W'(c);
      it.wheel_count_d       = COUNT_W'(d);
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it.distance_sixteenths = RANGE_W'($urandom);
      it.nav_mode            = 2'($urandom_range(0, 3));
      it.wheel_count_a       = COUNT_W'($urandom);
      it.wheel_count_b       = COUNT_W'($urandom);
      it.wheel_count_c       = COUNT_W'($urandom);
      it.wheel_count_d       = COUNT_W'($urandom);
      return it;
   endfunction

   function automatic void push_item(req_item_type it);
      pending_req_q.push_back(it);
      items_queued++;
   endfunction

   // Occasionally slip an idle or foreign-mode item into a sequence
   function automatic void push_step(req_item_type it);
      req_item_type extra;
      if ($urandom_range(0, 24) == 0) begin
         extra = noise_item();
         extra.nav_mode = $urandom_range(0, 1) ? MODE_IDLE : MODE_OTHER;
         push_item(extra);
      end
      push_item(it);
   endfunction

   function automatic logic [RANGE_W-1:0] scan_dist(bit blocked);
      int unsigned thr;
      thr = int'(thr_cm) << RANGE_FRAC_BITS;
      if (blocked && thr > 0) return RANGE_W'($urandom_range(0, thr - 1));
      return RANGE_W'($urandom_range(thr, 65535));
   endfunction

   function automatic void push_move(int unsigned target);
      repeat ($urandom_range(0, 3)) push_step(wheel_item('0, target, 1'b0));
      push_step(wheel_item(RANGE_W'($urandom), target, 1'b1));
   endfunction

   // One obstacle encounter: trigger, three scans, decision, then the moves unless all sides are blocked
   function automatic void queue_bypass();
      int unsigned        thr;
      bit                 all_blocked;
      logic [RANGE_W-1:0] left_d;
      logic [RANGE_W-1:0] right_d;
      thr         = int'(thr_cm) << RANGE_FRAC_BITS;
      all_blocked = ($urandom_range(0, 3) == 0);
      push_step(wheel_item(thr > 1 ? RANGE_W'($urandom_range(1, thr - 1))
                                   : RANGE_W'($urandom), 32768, $urandom_range(0, 1)));
      left_d  = scan_dist(all_blocked || $urandom_range(0, 1));
      right_d = scan_dist(all_blocked || $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) right_d = left_d;
      push_step(wheel_item(scan_dist(all_blocked || $urandom_range(0, 1)), 0, 1'b0));
      push_step(wheel_item(left_d, 0, 1'b0));
      push_step(wheel_item(right_d, 0, 1'b0));
      push_step(wheel_item(RANGE_W'($urandom), 32768, $urandom_range(0, 1)));
      if (!all_blocked) begin
         push_move(shift_tgt);
         push_move(fwd_tgt);
         push_move(shift_tgt);
      end
   endfunction

   initial begin
      int set_start;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: mode filtering, trigger edges, a left bypass, a full block, an abort
      push_item(fixed_item(500, MODE_OTHER, 0, 0, 0, 0));
      push_item(fixed_item(500, MODE_IDLE, 0, 0, 0, 0));
      push_item(fixed_item(0, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(640, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(639, MODE_RETURNING, 0, 0, 0, 0));
      push_item(fixed_item(0, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(65535, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(100, MODE_RETURNING, 0, 0, 0, 0));
      push_item(fixed_item(1234, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(0, MODE_GOING, 1000, 1000, 1000, 999));
      push_item(fixed_item(0, MODE_GOING, -32768, -32768, -32768, -32768));
      push_item(fixed_item(0, MODE_RETURNING, 32767, -32768, 0, 0));
      push_item(fixed_item(0, MODE_OTHER, 1000, 1000, 1000, 1000));
      push_item(fixed_item(0, MODE_GOING, 1000, -1000, 1000, -1000));
      push_item(fixed_item(1, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(0, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(639, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(1, MODE_RETURNING, 0, 0, 0, 0));
      push_item(fixed_item(7, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(320, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(5000, MODE_GOING, 0, 0, 0, 0));
      push_item(fixed_item(5000, MODE_IDLE, 0, 0, 0, 0));
      push_item(fixed_item(5000, MODE_IDLE, 0, 0, 0, 0));
      push_item(fixed_item(5000, MODE_OTHER, 0, 0, 0, 0));
      push_item(fixed_item(5000, MODE_GOING, 0, 0, 0, 0));

      // Random sequences under a series of register settings
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         if (s > 0) begin
            wait_drained();
            case (s)
               1:       apply_settings(4095, 0, 32767);
               2:       apply_settings(0, 32767, 0);
               3:       apply_settings(1, 1, 1);
               default: apply_settings($urandom_range(1, 300), $urandom_range(0, 32767),
                                       $urandom_range(0, 32767));
            endcase
         end
         burst_mode = (s == 1);
         set_start  = items_queued;
         while (items_queued - set_start < ITEMS_PER_SET) begin
            if ($urandom_range(0, 9) < 7) queue_bypass();
            else push_item(noise_item());
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Run covered %0d items under %0d register settings, %0d results checked",
               items_accepted, NUM_SETTINGS, results_checked);
      $display("Bypasses completed %0d, fully blocked stops %0d, aborts %0d, mismatches %0d",
               bypasses_done, blocked_stops, aborts_seen, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
